@@ sv/pipp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipp_pkg: shared types and constants
// Transaction payloads, queue entry layout and register codes for the
// projected point-in-polygon block.
// ----------------------------------------------------------------------------
package pipp_pkg;

   localparam logic [1:0] OP_POINT  = 2'd0;
   localparam logic [1:0] OP_NORMAL = 2'd1;
   localparam logic [1:0] OP_VERTEX = 2'd2;

   localparam logic       REG_ZERO_TOL = 1'b0;
   localparam logic [30:0] TOL_RESET   = 31'd66;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic [30:0]        in_w;
      logic               last;
   } req_type;

   typedef struct packed {
      logic        inside_res;
      logic [15:0] crossings;
   } rsp_type;

   // projected vertex job, with the point in the same kept axes
   typedef struct packed {
      logic signed [31:0] c1;
      logic signed [31:0] c2;
      logic [30:0]        w;
      logic               last;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } vtx_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

`default_nettype wire

@@ sv/pipp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipp_div: shared restoring divider
// One quotient bit per cycle; the remainder can be preloaded so that a
// fraction of a proper ratio is produced directly.
// ----------------------------------------------------------------------------
module pipp_div import pipp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [32:0]            rem_init,
   input  wire logic [32+FRAC_BITS-1:0] num_init,
   input  wire logic [32:0]            den,
   input  wire logic [$clog2(32+FRAC_BITS+1)-1:0] steps,
   output logic                        done,
   output logic [32+FRAC_BITS-1:0]     quo
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [32:0]   rem_ff, rem_in;
   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [32:0]   den_ff, den_in;
   logic [33:0]   rem_sh;
   logic          ge;

   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         num_in  = num_init;
         quo_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? 33'(rem_sh - {1'b0, den_ff}) : rem_sh[32:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

@@ sv/pipp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipp_fifo: vertex job queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module pipp_fifo import pipp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire vtx_type push_data,
   input  wire logic    pop,
   output vtx_type      pop_data,
   output q_status_type status
);

   vtx_type    mem [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign do_push = push && (cnt_ff != 2'd2);
   assign do_pop  = pop && (cnt_ff != 2'd0);

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= push_data;
      end
   end

   assign pop_data         = mem[rp_ff];
   assign status.full      = cnt_ff == 2'd2;
   assign status.not_empty = cnt_ff != 2'd0;

endmodule

`default_nettype wire

@@ sv/pipp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipp_front: command decode
// Holds the point and the dropped axis, and turns each vertex into a job
// with its kept coordinates and the matching point coordinates.
// ----------------------------------------------------------------------------
module pipp_front import pipp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output logic         push,
   output vtx_type      job
);

   logic signed [31:0] pt_ff [3];
   logic signed [31:0] pt_in [3];
   logic [1:0]         drop_ff, drop_in;
   logic [31:0]        m0, m1, m2;
   logic [1:0]         ax;
   logic [31:0]        best;

   function automatic logic [31:0] mag32(logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   always_comb begin
      m0   = mag32(req.in_x);
      m1   = mag32(req.in_y);
      m2   = mag32(req.in_z);
      ax   = 2'd0;
      best = m0;
      if (m1 > best) begin
         ax   = 2'd1;
         best = m1;
      end
      if (m2 > best) begin
         ax = 2'd2;
      end
   end

   always_comb begin
      pt_in   = pt_ff;
      drop_in = drop_ff;
      if (accept && req.op == OP_POINT) begin
         pt_in[0] = req.in_x;
         pt_in[1] = req.in_y;
         pt_in[2] = req.in_z;
      end
      if (accept && req.op == OP_NORMAL) begin
         drop_in = ax;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff[0] <= '0;
         pt_ff[1] <= '0;
         pt_ff[2] <= '0;
         drop_ff  <= '0;
      end else begin
         pt_ff   <= pt_in;
         drop_ff <= drop_in;
      end
   end

   // kept axes are the two that follow the dropped one, cyclically
   always_comb begin
      job.w    = req.in_w;
      job.last = req.last;
      case (drop_ff)
         2'd1: begin
            job.c1 = req.in_z;
            job.c2 = req.in_x;
            job.p1 = pt_ff[2];
            job.p2 = pt_ff[0];
         end
         2'd2: begin
            job.c1 = req.in_x;
            job.c2 = req.in_y;
            job.p1 = pt_ff[0];
            job.p2 = pt_ff[1];
         end
         default: begin
            job.c1 = req.in_y;
            job.c2 = req.in_z;
            job.p1 = pt_ff[1];
            job.p2 = pt_ff[2];
         end
      endcase
   end

   assign push = accept && req.op == OP_VERTEX;

endmodule

`default_nettype wire

@@ sv/pipp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipp_back: vertex and edge sequencer
// Divides each vertex by its weight, tests the edges against the ray and
// keeps the crossing count and parity of the ring.
// ----------------------------------------------------------------------------
module pipp_back import pipp_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [30:0]   tol,
   input  wire q_status_type  q_status,
   input  wire vtx_type       q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   output rsp_type            rsp_item
);

   localparam int NW   = 32 + FRAC_BITS;
   localparam int CW   = $clog2(NW + 1);
   localparam int PW   = 34 + FRAC_BITS;
   localparam int SW   = PW + 1;
   localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   typedef enum logic [3:0] {
      ST_IDLE, ST_UGO, ST_UWAIT, ST_VGO, ST_VWAIT, ST_PREP, ST_EDGE,
      ST_EDIV, ST_EMUL, ST_ESUM, ST_STORE, ST_DONE
   } state_type;

   state_type              state_ff;
   vtx_type                ent_ff;
   logic signed [31:0]     cu_ff, cv_ff;
   logic signed [31:0]     pu_ff, pv_ff;
   logic signed [31:0]     fu_ff, fv_ff;
   logic                   have_first_ff;
   logic signed [31:0]     eb1_ff, eb2_ff, ea1_ff, ea2_ff;
   logic                   closing_ff;
   logic [FRAC_BITS-1:0]   s_ff;
   logic signed [PW-1:0]   prod_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic                   parity_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   div_start, div_done;
   logic [32:0]            div_rem, div_den;
   logic [NW-1:0]          div_num, div_quo;
   logic [CW-1:0]          div_steps;

   logic signed [32:0]     d, n, t, e, bp;
   logic [32:0]            ad, an, at, ae;
   logic                   par, par_cross, div_ok, opposite, w_nz;
   logic signed [SW-1:0]   sum;
   logic [WIDE-1:0]        cnt_wide;

   function automatic logic [32:0] mag33(logic signed [32:0] v);
      mag33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic [31:0] mag32(logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [31:0] wconv(logic [NW-1:0] q, logic neg);
      if (!neg) begin
         wconv = (q > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
      end else begin
         wconv = (q > NW'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-q[31:0]);
      end
   endfunction

   function automatic logic signed [31:0] wzero(logic signed [31:0] c);
      if (c == 0) begin
         wzero = '0;
      end else begin
         wzero = c[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   endfunction

   assign w_nz = ent_ff.w != '0;

   always_comb begin
      d  = 33'(ea2_ff) - 33'(eb2_ff);
      n  = 33'(ent_ff.p2) - 33'(eb2_ff);
      t  = 33'(ent_ff.p1) - 33'(eb1_ff);
      e  = 33'(ea1_ff) - 33'(eb1_ff);
      bp = 33'(eb1_ff) - 33'(ent_ff.p1);
      ad = mag33(d);
      an = mag33(n);
      at = mag33(t);
      ae = mag33(e);
      par      = ad < {2'b00, tol};
      opposite = (t < 0 && e > 0) || (t > 0 && e < 0);
      par_cross = !opposite && (at < ae) && (an < ad);
      // only a strictly positive fraction below one can cross
      div_ok = (d != 0) && (n != 0) && (n[32] == d[32]) && (an < ad);
      sum = SW'(prod_ff) + (SW'(bp) <<< FRAC_BITS);
   end

   always_comb begin
      div_start = 1'b0;
      div_rem   = '0;
      div_num   = '0;
      div_den   = {2'b00, ent_ff.w};
      div_steps = CW'(NW);
      case (state_ff)
         ST_UGO: begin
            div_start = w_nz;
            div_num   = {mag32(ent_ff.c1), FRAC_BITS'(0)};
         end
         ST_VGO: begin
            div_start = w_nz;
            div_num   = {mag32(ent_ff.c2), FRAC_BITS'(0)};
         end
         ST_EDGE: begin
            div_start = !par && div_ok;
            div_rem   = an;
            div_den   = ad;
            div_steps = CW'(FRAC_BITS);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   pipp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .num_init (div_num),
      .den      (div_den),
      .steps    (div_steps),
      .done     (div_done),
      .quo      (div_quo)
   );

   assign q_pop = (state_ff == ST_IDLE) && q_status.not_empty;

   always_comb begin
      cnt_wide = WIDE'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_first_ff <= 1'b0;
         cnt_ff        <= '0;
         parity_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         closing_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_status.not_empty) begin
                  ent_ff   <= q_data;
                  state_ff <= ST_UGO;
               end
            end
            ST_UGO: begin
               state_ff <= ST_UWAIT;
            end
            ST_UWAIT: begin
               if (!w_nz) begin
                  cu_ff    <= wzero(ent_ff.c1);
                  state_ff <= ST_VGO;
               end else if (div_done) begin
                  cu_ff    <= wconv(div_quo, ent_ff.c1[31]);
                  state_ff <= ST_VGO;
               end
            end
            ST_VGO: begin
               state_ff <= ST_VWAIT;
            end
            ST_VWAIT: begin
               if (!w_nz) begin
                  cv_ff    <= wzero(ent_ff.c2);
                  state_ff <= ST_PREP;
               end else if (div_done) begin
                  cv_ff    <= wconv(div_quo, ent_ff.c2[31]);
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (have_first_ff) begin
                  eb1_ff     <= pu_ff;
                  eb2_ff     <= pv_ff;
                  ea1_ff     <= cu_ff;
                  ea2_ff     <= cv_ff;
                  closing_ff <= 1'b0;
                  state_ff   <= ST_EDGE;
               end else begin
                  state_ff <= ST_STORE;
               end
            end
            ST_EDGE: begin
               if (par) begin
                  if (par_cross) begin
                     if (cnt_ff != '1) begin
                        cnt_ff <= cnt_ff + COUNT_BITS'(1);
                     end
                     parity_ff <= ~parity_ff;
                  end
                  state_ff <= closing_ff ? ST_DONE : ST_STORE;
               end else if (div_ok) begin
                  state_ff <= ST_EDIV;
               end else begin
                  state_ff <= closing_ff ? ST_DONE : ST_STORE;
               end
            end
            ST_EDIV: begin
               if (div_done) begin
                  s_ff <= div_quo[FRAC_BITS-1:0];
                  if (div_quo[FRAC_BITS-1:0] == '0) begin
                     state_ff <= closing_ff ? ST_DONE : ST_STORE;
                  end else begin
                     state_ff <= ST_EMUL;
                  end
               end
            end
            ST_EMUL: begin
               prod_ff  <= PW'($signed({1'b0, s_ff}) * e);
               state_ff <= ST_ESUM;
            end
            ST_ESUM: begin
               if (!sum[SW-1]) begin
                  if (cnt_ff != '1) begin
                     cnt_ff <= cnt_ff + COUNT_BITS'(1);
                  end
                  parity_ff <= ~parity_ff;
               end
               state_ff <= closing_ff ? ST_DONE : ST_STORE;
            end
            ST_STORE: begin
               pu_ff         <= cu_ff;
               pv_ff         <= cv_ff;
               have_first_ff <= 1'b1;
               if (!have_first_ff) begin
                  fu_ff <= cu_ff;
                  fv_ff <= cv_ff;
               end
               if (ent_ff.last) begin
                  // closing edge back to the first vertex
                  eb1_ff     <= cu_ff;
                  eb2_ff     <= cv_ff;
                  ea1_ff     <= have_first_ff ? fu_ff : cu_ff;
                  ea2_ff     <= have_first_ff ? fv_ff : cv_ff;
                  closing_ff <= 1'b1;
                  state_ff   <= ST_EDGE;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DONE: begin
               rsp_valid_ff       <= 1'b1;
               rsp_ff.inside_res  <= parity_ff;
               rsp_ff.crossings   <= (cnt_wide > WIDE'(16'hFFFF)) ? 16'hFFFF
                                                                 : cnt_wide[15:0];
               cnt_ff        <= '0;
               parity_ff     <= 1'b0;
               have_first_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ sv/point_in_polygon_projected_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_projected_top: point-in-polygon test in the principal plane
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   op 0 loads the point and op 1 the plane normal; both take effect at once.
//   op 2 queues a homogeneous vertex; last closes the ring. Vertices go to a
//   two-entry queue and busy is high while it is full.
//   Each vertex runs through one shared restoring divider, one bit a cycle:
//   two weight divisions (none for a zero weight), then a fraction division
//   for an edge that is not near parallel and may cross. The closing vertex
//   also tests the edge back to the first vertex.
//   The result (inside flag, crossing count) appears on rsp_item for one
//   cycle with rsp_valid; the receiver cannot stall it.
//   zero_tolerance is written over the csr port at byte address 0; the user
//   must do so while the block is idle, as the block does not enforce it.
//   Reset clears the point, the normal choice, the ring and the queue, and
//   sets zero_tolerance to 66.
// ----------------------------------------------------------------------------
module point_in_polygon_projected_top import pipp_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [30:0]  tol_ff, tol_in;
   logic         accept, csr_wr;
   logic         push, pop;
   vtx_type      job, q_data;
   q_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign tol_in     = (csr_wr && csr_paddr[2] == REG_ZERO_TOL) ? csr_pwdata[30:0]
                                                                : tol_ff;
   assign csr_prdata = (csr_paddr[2] == REG_ZERO_TOL) ? {1'b0, tol_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   assign busy   = q_status.full;
   assign accept = start && !busy;

   pipp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_item),
      .push   (push),
      .job    (job)
   );

   pipp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job),
      .pop       (pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   pipp_back #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tol       (tol_ff),
      .q_status  (q_status),
      .q_data    (q_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // two results never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // odd parity needs at least one counted crossing
   a_parity_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.inside_res) |-> (rsp_item.crossings != 16'd0))
      else $error("inside with zero crossings");

   // a pop only happens when the queue holds a job
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ tb/tb_point_in_polygon_projected_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_projected_top: point-in-polygon block testbench
// Drives command transactions (point, normal, vertex rings) with random
// gaps, predicts each ring verdict with a local crossing-rule model and
// checks every result transaction in order; writes zero_tolerance between
// phases at several settings including both extremes.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_projected_top;
   import pipp_pkg::*;

   localparam longint ONE        = 64'sd65536;
   localparam int     DRAIN_CYC  = 400;
   localparam longint MAX_CYCLES = 4000000;
   localparam int     N_ITEMS    = 1400;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   point_in_polygon_projected_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [30:0]        tol;
   logic signed [31:0] pt [3];
   int                 drop;
   longint             first_u, first_v, prev_u, prev_v;
   int                 cross_cnt;
   logic               cross_odd;
   logic               have_first;

   rsp_type verdict_q[$];
   int      err_cnt;
   int      sent_cnt;
   int      idle_pct;
   longint  cycle_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint by_weight(longint c, longint w);
      longint q;
      if (w == 0) return c > 0 ? 64'sd2147483647 : (c < 0 ? -64'sd2147483648 : 0);
      q = (c * ONE) / w;
      if (q > 64'sd2147483647) return 64'sd2147483647;
      if (q < -64'sd2147483648) return -64'sd2147483648;
      return q;
   endfunction

   function automatic void count_crossing();
      if (cross_cnt < 65535) cross_cnt++;
      cross_odd = ~cross_odd;
   endfunction

   // edge from b to a against the ray from the point
   function automatic void test_edge(longint b1, longint b2, longint a1, longint a2);
      longint p1, p2, d, n, s, sum, t, e;
      logic   opposite;
      p1 = pt[(drop + 1) % 3];
      p2 = pt[(drop + 2) % 3];
      d  = a2 - b2;
      n  = p2 - b2;
      if (mag(d) >= longint'(tol)) begin
         if (d == 0) return;
         s = (n * ONE) / d;
         if (s > 0 && s < ONE) begin
            sum = s * a1 + (ONE - s) * b1 - p1 * ONE;
            if (sum >= 0) count_crossing();
         end
      end else begin
         t = p1 - b1;
         e = a1 - b1;
         opposite = (t < 0 && e > 0) || (t > 0 && e < 0);
         if (!opposite && mag(t) < mag(e) && mag(n) < mag(d)) count_crossing();
      end
   endfunction

   function automatic void predict_ring(req_type r);
      longint  c [3];
      longint  best, u, v;
      rsp_type verdict;
      c[0] = r.in_x;
      c[1] = r.in_y;
      c[2] = r.in_z;
      case (r.op)
         OP_POINT: begin
            pt[0] = r.in_x;
            pt[1] = r.in_y;
            pt[2] = r.in_z;
         end
         OP_NORMAL: begin
            best = 0;
            drop = 0;
            for (int i = 0; i < 3; i++) begin
               if (mag(c[i]) > best) begin
                  best = mag(c[i]);
                  drop = i;
               end
            end
         end
         OP_VERTEX: begin
            u = by_weight(c[(drop + 1) % 3], longint'(r.in_w));
            v = by_weight(c[(drop + 2) % 3], longint'(r.in_w));
            if (!have_first) begin
               first_u = u;
               first_v = v;
               have_first = 1'b1;
            end else begin
               test_edge(prev_u, prev_v, u, v);
            end
            prev_u = u;
            prev_v = v;
            if (r.last) begin
               test_edge(u, v, first_u, first_v);
               verdict.inside_res = cross_odd;
               verdict.crossings  = cross_cnt[15:0];
               verdict_q.push_back(verdict);
               cross_cnt  = 0;
               cross_odd  = 1'b0;
               have_first = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // leaves start high when no gap follows, so the next transaction goes back to back
   task automatic send_item(req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predict_ring(r);
      sent_cnt++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   endtask

   task automatic send_cmd(logic [1:0] op, longint x, longint y, longint z,
                           longint w = ONE, logic last = 1'b0);
      req_type r;
      r.op   = op;
      r.in_x = 32'(x);
      r.in_y = 32'(y);
      r.in_z = 32'(z);
      r.in_w = 31'(w);
      r.last = last;
      send_item(r);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [30:0] value);
      wait_drained();
      repeat (DRAIN_CYC) @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= 3'd4 * REG_ZERO_TOL;
      csr_pwdata <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tol = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[30:0] !== value) begin
         err_cnt++;
         if (err_cnt <= 10)
            $display("tolerance readback: expected %0d actual %0d", value, csr_prdata[30:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // ring through the unit-square corners in the kept plane, after a given normal
   task automatic square_ring(longint nx, longint ny, longint nz, longint px, longint py);
      send_cmd(OP_NORMAL, nx, ny, nz);
      send_cmd(OP_POINT, px, py, px);
      send_cmd(OP_VERTEX, 0, 0, 0);
      send_cmd(OP_VERTEX, ONE, ONE, ONE);
      send_cmd(OP_VERTEX, 2 * ONE, 0, 2 * ONE, 2 * ONE);
      send_cmd(OP_VERTEX, 0, ONE, 0, ONE, 1'b1);
   endtask

   task automatic test_normal_choice();
      square_ring(0, 0, 0, ONE / 2, ONE / 2);
      square_ring(5, -5, 3, ONE / 3, ONE / 4);
      square_ring(1, -7, 7, 2 * ONE, ONE / 2);
      square_ring(3, 2, -64'sd2147483648, ONE / 2, ONE / 2);
   endtask

   task automatic test_edge_cases();
      // single-vertex ring
      send_cmd(OP_VERTEX, ONE, ONE, ONE, ONE, 1'b1);
      // point on an edge, extreme coordinates saturate
      send_cmd(OP_POINT, ONE, 0, 0);
      send_cmd(OP_VERTEX, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 1);
      send_cmd(OP_VERTEX, 0, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
      // load mid-ring
      send_cmd(OP_POINT, -ONE, ONE / 2, -ONE);
      send_cmd(OP_VERTEX, -2 * ONE, 0, ONE, ONE, 1'b1);
      // vertical edge through the point
      send_cmd(OP_POINT, 0, ONE, ONE);
      send_cmd(OP_VERTEX, 0, -ONE, ONE, 1);
      send_cmd(OP_VERTEX, 0, 3 * ONE, ONE);
      send_cmd(OP_VERTEX, 0, 3 * ONE, 3 * ONE, ONE, 1'b1);
   endtask

   function automatic longint rand_coord(logic noisy);
      if (noisy) return longint'($signed($urandom));
      return $signed($urandom_range(16 * 65536)) - 8 * ONE;
   endfunction

   task automatic random_rings(int n_target);
      int     nv;
      logic   noisy;
      longint w;
      while (sent_cnt < n_target) begin
         noisy = ($urandom_range(9) == 0);
         if ($urandom_range(3) == 0)
            send_cmd(OP_NORMAL, rand_coord(noisy), rand_coord(noisy), rand_coord(noisy));
         send_cmd(OP_POINT, rand_coord(noisy), rand_coord(noisy), rand_coord(noisy));
         nv = $urandom_range(8, 1);
         for (int i = 0; i < nv; i++) begin
            case ($urandom_range(3))
               0: w = ONE;
               1: w = $urandom_range(4 * 65536, 1);
               2: w = $urandom_range(32'h7fffffff, 1);
               default: w = ONE / 2;
            endcase
            // occasional load inside the ring
            if ($urandom_range(29) == 0)
               send_cmd(OP_POINT, rand_coord(noisy), rand_coord(noisy), rand_coord(noisy));
            send_cmd(OP_VERTEX, rand_coord(noisy), rand_coord(noisy), rand_coord(noisy), w,
                     i == nv - 1);
         end
         if ($urandom_range(49) == 0) wait_drained();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
               $display("unexpected result: inside %0b crossings %0d",
                        rsp_item.inside_res, rsp_item.crossings);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_item.inside_res !== want.inside_res ||
                rsp_item.crossings !== want.crossings) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("result mismatch: expected inside %0b crossings %0d, actual %0b %0d",
                           want.inside_res, want.crossings,
                           rsp_item.inside_res, rsp_item.crossings);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > MAX_CYCLES) begin
         $display("tb_point_in_polygon_projected_top: done, errors");
         $finish;
      end
   end

   initial begin
      cycle_cnt   = 0;
      err_cnt     = 0;
      sent_cnt    = 0;
      idle_pct    = 0;
      tol         = TOL_RESET;
      pt[0]       = 0;
      pt[1]       = 0;
      pt[2]       = 0;
      drop        = 0;
      cross_cnt   = 0;
      cross_odd   = 1'b0;
      have_first  = 1'b0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_item    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_normal_choice();
      test_edge_cases();
      write_tolerance('0);
      test_edge_cases();
      write_tolerance(31'h7fffffff);
      test_normal_choice();

      idle_pct = 33;
      write_tolerance(TOL_RESET);
      random_rings(N_ITEMS / 3);
      idle_pct = 62;
      write_tolerance(31'($urandom_range(65536)));
      random_rings(2 * N_ITEMS / 3);
      idle_pct = 0;
      write_tolerance('0);
      random_rings(N_ITEMS);

      wait_drained();
      repeat (DRAIN_CYC) @(posedge clock);
      if (err_cnt == 0) begin
         $display("tb_point_in_polygon_projected_top: done, clean");
      end else begin
         $display("tb_point_in_polygon_projected_top: done, errors");
      end
      $finish;
   end

endmodule
